// File: rtl/dbnc_pkg.sv
// Package for the multi-channel asymmetric debouncer.
// Holds field widths, register index codes and the shared struct types.
// No dependencies.
package dbnc_pkg;

  // Fixed widths of the word fields and the configuration port.
  localparam int FIELD_BITS     = 8;
  localparam int HOLD_BITS      = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // Defaults for the top-level parameters.
  localparam int CHANNELS_DEFAULT   = 8;
  localparam int COUNT_BITS_DEFAULT = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_RISE_HOLD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FALL_HOLD = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ON_LEVEL  = 2'd2;

  // Register values shared by every lane.
  typedef struct packed {
    logic [HOLD_BITS-1:0] rise_hold;
    logic [HOLD_BITS-1:0] fall_hold;
    logic                 on_level;
  } cfg_regs_t;

  // Per-channel status after the current tick.
  typedef struct packed {
    logic stable;
    logic rise;
    logic fall;
  } lane_status_t;

endpackage

// File: rtl/dbnc_in_if.sv
// Input channel of the debouncer: one sampling tick per word.
// Depends on dbnc_pkg for the field width.
interface dbnc_in_if
  import dbnc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] sample_bits;
  logic [FIELD_BITS-1:0] clear_rise_mask;
  logic [FIELD_BITS-1:0] clear_fall_mask;

  modport source (output valid, sample_bits, clear_rise_mask, clear_fall_mask, input ready);
  modport sink   (input valid, sample_bits, clear_rise_mask, clear_fall_mask, output ready);
endinterface

// File: rtl/dbnc_out_if.sv
// Output channel of the debouncer: levels and sticky flags per word.
// Depends on dbnc_pkg for the field width.
interface dbnc_out_if
  import dbnc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] stable_bits;
  logic [FIELD_BITS-1:0] rise_flags;
  logic [FIELD_BITS-1:0] fall_flags;

  modport source (output valid, stable_bits, rise_flags, fall_flags, input ready);
  modport sink   (input valid, stable_bits, rise_flags, fall_flags, output ready);
endinterface

// File: rtl/dbnc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on dbnc_pkg for the index and data widths.
interface dbnc_cfg_if
  import dbnc_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/dbnc_lane.sv
// One debouncer channel: stable level, saturating mismatch counter, sticky flags.
// Depends on dbnc_pkg for cfg_regs_t and lane_status_t.
module dbnc_lane
  import dbnc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         tick,
  input  logic         raw,
  input  logic         clr_rise,
  input  logic         clr_fall,
  input  cfg_regs_t    cfg_regs,
  output lane_status_t status_next
);

  localparam int CMP_BITS = (COUNT_BITS > HOLD_BITS) ? COUNT_BITS : HOLD_BITS;

  logic                  stable;
  logic                  rise;
  logic                  fall;
  logic [COUNT_BITS-1:0] count;

  logic                  stable_next;
  logic                  rise_next;
  logic                  fall_next;
  logic [COUNT_BITS-1:0] count_next;
  logic                  at_on;
  logic [HOLD_BITS-1:0]  hold;
  logic                  commit;

  // Count up while the raw level differs, saturating; drop to zero on a match.
  always_comb begin
    if (raw != stable) begin
      count_next = (&count) ? count : count + COUNT_BITS'(1);
    end else begin
      count_next = '0;
    end
  end

  // The hold that applies depends on which side the stable level sits.
  assign at_on  = (stable == cfg_regs.on_level);
  assign hold   = at_on ? cfg_regs.rise_hold : cfg_regs.fall_hold;
  assign commit = CMP_BITS'(count_next) > CMP_BITS'(hold);

  // Clears act before a commit, so a commit in the same tick wins.
  assign stable_next = commit ? raw : stable;
  assign rise_next   = (rise & ~clr_rise) | (commit & at_on);
  assign fall_next   = (fall & ~clr_fall) | (commit & ~at_on);

  assign status_next = '{stable: stable_next, rise: rise_next, fall: fall_next};

  // Channel state advances once per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= 1'b0;
      rise   <= 1'b0;
      fall   <= 1'b0;
      count  <= '0;
    end else if (tick) begin
      stable <= stable_next;
      rise   <= rise_next;
      fall   <= fall_next;
      count  <= count_next;
    end
  end

endmodule

// File: rtl/dbnc_merge.sv
// Merging stage: packs the lane status into a result word and buffers two words.
// Depends on dbnc_pkg and the dbnc_out_if interface.
module dbnc_merge
  import dbnc_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         tick,
  input  lane_status_t lane_st [CHANNELS],
  output logic         space,
  dbnc_out_if.source   results
);

  localparam int WORD_BITS = 3 * FIELD_BITS;

  logic [FIELD_BITS-1:0] stable_w;
  logic [FIELD_BITS-1:0] rise_w;
  logic [FIELD_BITS-1:0] fall_w;
  logic [WORD_BITS-1:0]  slot [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            fill;
  logic                  take;

  // Gather one bit per channel; channels beyond the field width are dropped.
  for (genvar c = 0; c < FIELD_BITS; c++) begin : g_pack
    if (c < CHANNELS) begin : g_lane
      assign stable_w[c] = lane_st[c].stable;
      assign rise_w[c]   = lane_st[c].rise;
      assign fall_w[c]   = lane_st[c].fall;
    end else begin : g_none
      assign stable_w[c] = 1'b0;
      assign rise_w[c]   = 1'b0;
      assign fall_w[c]   = 1'b0;
    end
  end

  assign take  = results.valid & results.ready;
  assign space = (fill != 2'd2);

  // Two-word buffer, so input stays ready while a word waits downstream.
  always_ff @(posedge clk) begin
    if (tick) begin
      slot[wr_ptr] <= {stable_w, rise_w, fall_w};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (tick) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      if (tick && !take) begin
        fill <= fill + 2'd1;
      end else if (take && !tick) begin
        fill <= fill - 2'd1;
      end
    end
  end

  assign results.valid       = (fill != 2'd0);
  assign results.stable_bits = slot[rd_ptr][WORD_BITS-1 -: FIELD_BITS];
  assign results.rise_flags  = slot[rd_ptr][2*FIELD_BITS-1 -: FIELD_BITS];
  assign results.fall_flags  = slot[rd_ptr][FIELD_BITS-1:0];

  // The buffer never holds more than two words.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("result buffer overfilled");

  // A word written with nothing taken raises the fill level by one.
  a_fill_up: assert property (@(posedge clk) disable iff (rst)
    (tick && !take) |=> (fill == $past(fill) + 2'd1))
    else $error("fill level did not follow a write");

  // The pointers differ exactly when the buffer holds one word.
  a_ptr_fill: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr != rd_ptr) == (fill == 2'd1))
    else $error("pointers disagree with fill level");

  // A word accepted into an empty buffer is offered on the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (tick && fill == 2'd0) |=> results.valid)
    else $error("result not offered after a write");

endmodule

// File: rtl/multi_channel_asymmetric_debouncer.sv
// Multi-channel asymmetric debouncer. Each input word is one sampling tick: a raw bit
// per channel and two clear masks for the sticky rise and fall flags. Every channel
// runs its own lane (a saturating mismatch counter, a compare against the rise or fall
// hold and the flag logic), and all lanes update in the cycle a word is accepted, so the
// block takes one word per cycle while the output buffer has space. Each result word
// goes into a two-word output buffer, which keeps input ready while results wait.
// Configuration writes are always accepted; write only while the block is idle.
// Depends on dbnc_pkg, the three channel interfaces, dbnc_lane and dbnc_merge.
module multi_channel_asymmetric_debouncer
  import dbnc_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEFAULT,
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  dbnc_cfg_if.sink   cfg,
  dbnc_in_if.sink    samples,
  dbnc_out_if.source results
);

  cfg_regs_t    cfg_regs;
  logic         tick;
  logic         space;
  lane_status_t lane_st [CHANNELS];

  // Configuration registers; writes to unused indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.rise_hold <= '0;
      cfg_regs.fall_hold <= '0;
      cfg_regs.on_level  <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_RISE_HOLD: cfg_regs.rise_hold <= cfg.data[HOLD_BITS-1:0];
        REG_FALL_HOLD: cfg_regs.fall_hold <= cfg.data[HOLD_BITS-1:0];
        REG_ON_LEVEL:  cfg_regs.on_level  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign samples.ready = space;
  assign tick          = samples.valid & space;

  // One lane per channel; channels beyond the field width see a raw 0 and no clears.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic raw;
    logic clr_rise;
    logic clr_fall;

    if (c < FIELD_BITS) begin : g_in
      assign raw      = samples.sample_bits[c];
      assign clr_rise = samples.clear_rise_mask[c];
      assign clr_fall = samples.clear_fall_mask[c];
    end else begin : g_none
      assign raw      = 1'b0;
      assign clr_rise = 1'b0;
      assign clr_fall = 1'b0;
    end

    dbnc_lane #(
      .COUNT_BITS(COUNT_BITS)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .tick       (tick),
      .raw        (raw),
      .clr_rise   (clr_rise),
      .clr_fall   (clr_fall),
      .cfg_regs   (cfg_regs),
      .status_next(lane_st[c])
    );
  end

  // Pack lane results into the output word and buffer it.
  dbnc_merge #(
    .CHANNELS(CHANNELS)
  ) u_merge (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick),
    .lane_st(lane_st),
    .space  (space),
    .results(results)
  );

endmodule

// File: verif/dbnc_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the multi-channel asymmetric debouncer testbench: a per-channel
// predictor of levels, counters and sticky flags, and the queue of expected words.
// Depends on dbnc_pkg for widths, register indexes and default sizes.
package dbnc_tb_pkg;
  import dbnc_pkg::*;

  // One result word as seen on the output channel.
  typedef struct packed {
    logic [FIELD_BITS-1:0] stable;
    logic [FIELD_BITS-1:0] rise;
    logic [FIELD_BITS-1:0] fall;
  } tick_word_t;

  class debounce_scoreboard;
    logic [HOLD_BITS-1:0]          rise_hold;
    logic [HOLD_BITS-1:0]          fall_hold;
    logic                          on_level;
    logic [CHANNELS_DEFAULT-1:0]   level_q;
    logic [CHANNELS_DEFAULT-1:0]   rise_q;
    logic [CHANNELS_DEFAULT-1:0]   fall_q;
    logic [COUNT_BITS_DEFAULT-1:0] mismatch_q [CHANNELS_DEFAULT];
    tick_word_t                    expected_q [$];
    int                            errors;
    int                            noted;
    int                            checked;
    int                            rise_commits;
    int                            fall_commits;

    // Register and lane state as after reset.
    function new();
      rise_hold    = '0;
      fall_hold    = '0;
      on_level     = 1'b1;
      level_q      = '0;
      rise_q       = '0;
      fall_q       = '0;
      errors       = 0;
      noted        = 0;
      checked      = 0;
      rise_commits = 0;
      fall_commits = 0;
      foreach (mismatch_q[c]) mismatch_q[c] = '0;
    endfunction

    // A write to an index with no register behind it changes nothing.
    function void write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                            input logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_RISE_HOLD: rise_hold = data;
        REG_FALL_HOLD: fall_hold = data;
        REG_ON_LEVEL:  on_level  = data[0];
        default: ;
      endcase
    endfunction

    // Advance every lane by one sampling tick and queue the word it produces.
    function void note_tick(input logic [FIELD_BITS-1:0] raw,
                            input logic [FIELD_BITS-1:0] clr_rise,
                            input logic [FIELD_BITS-1:0] clr_fall);
      tick_word_t want;
      for (int c = 0; c < CHANNELS_DEFAULT; c++) begin
        // Clears act before the update, so a commit in the same tick wins.
        if (clr_rise[c]) rise_q[c] = 1'b0;
        if (clr_fall[c]) fall_q[c] = 1'b0;
        // The counter saturates and is left alone by a commit.
        if (raw[c] != level_q[c]) begin
          if (mismatch_q[c] != '1) mismatch_q[c] = mismatch_q[c] + 1'b1;
        end else begin
          mismatch_q[c] = '0;
        end
        if (level_q[c] == on_level) begin
          if (mismatch_q[c] > rise_hold) begin
            level_q[c] = raw[c];
            rise_q[c]  = 1'b1;
            rise_commits++;
          end
        end else if (mismatch_q[c] > fall_hold) begin
          level_q[c] = raw[c];
          fall_q[c]  = 1'b1;
          fall_commits++;
        end
      end
      want.stable = level_q;
      want.rise   = rise_q;
      want.fall   = fall_q;
      expected_q.push_back(want);
      noted++;
    endfunction

    // Compare an accepted result word with the oldest expectation.
    function void check_word(input tick_word_t got);
      tick_word_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word, stable %02h rise %02h fall %02h",
                 $time, got.stable, got.rise, got.fall);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.stable !== want.stable) begin
        $display("%0t: stable_bits expected %02h, got %02h", $time, want.stable, got.stable);
        errors++;
      end
      if (got.rise !== want.rise) begin
        $display("%0t: rise_flags expected %02h, got %02h", $time, want.rise, got.rise);
        errors++;
      end
      if (got.fall !== want.fall) begin
        $display("%0t: fall_flags expected %02h, got %02h", $time, want.fall, got.fall);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench of the multi-channel asymmetric debouncer: directed ticks,
// a long run against high holds and randomised bouncing inputs under several settings.
// Depends on dbnc_pkg, dbnc_tb_pkg, the three channel interfaces and the block itself.
module tb_top;
  import dbnc_pkg::*;
  import dbnc_tb_pkg::*;

  localparam int                        IDLE_PCT       = 37;
  localparam int                        DRAIN_PAD      = 4;
  localparam int                        HOLDOFF_CYCLES = 400;
  localparam int                        QUIET_LIMIT    = 4000;
  localparam int                        RANDOM_PHASES  = 8;
  localparam int                        PHASE_WORDS    = 180;
  localparam int                        LONG_TICKS     = 60;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE      = 2'd3;

  logic clk = 1'b0;
  logic rst;
  bit   gaps_on;
  bit   stall_req;
  bit   stall_done;
  int   stall_left;
  int   quiet_cycles;
  int   settings;
  logic [FIELD_BITS-1:0] target_level;

  debounce_scoreboard sb;

  dbnc_cfg_if cfg_ch ();
  dbnc_in_if  sample_ch ();
  dbnc_out_if result_ch ();

  multi_channel_asymmetric_debouncer #(
    .CHANNELS   (CHANNELS_DEFAULT),
    .COUNT_BITS (COUNT_BITS_DEFAULT)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (sample_ch),
    .results (result_ch)
  );

  always #6 clk = ~clk;

  // Offer one sampling word, with random idle cycles ahead of it, and wait for it.
  task automatic send_tick(input logic [FIELD_BITS-1:0] raw,
                           input logic [FIELD_BITS-1:0] clr_rise,
                           input logic [FIELD_BITS-1:0] clr_fall);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid           <= 1'b1;
    sample_ch.sample_bits     <= raw;
    sample_ch.clear_rise_mask <= clr_rise;
    sample_ch.clear_fall_mask <= clr_fall;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sb.note_tick(raw, clr_rise, clr_fall);
  endtask

  // Stop offering words and wait for every outstanding result.
  task automatic pause_until_drained();
    sample_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Registers change only once the block has gone quiet.
  task automatic apply_setting(input logic [CFG_DATA_BITS-1:0] rise_v,
                               input logic [CFG_DATA_BITS-1:0] fall_v,
                               input logic [CFG_DATA_BITS-1:0] on_v,
                               input bit spare);
    pause_until_drained();
    repeat (DRAIN_PAD) @(posedge clk);
    if (spare) write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
    write_reg(REG_RISE_HOLD, rise_v);
    write_reg(REG_FALL_HOLD, fall_v);
    write_reg(REG_ON_LEVEL, on_v);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // Result side: check accepted words and drive ready, with one long hold-off on request.
  initial begin
    result_ch.ready = 1'b0;
    stall_left      = 0;
    stall_done      = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready)
        sb.check_word({result_ch.stable_bits, result_ch.rise_flags, result_ch.fall_flags});
      if (stall_req && !stall_done) begin
        stall_left = HOLDOFF_CYCLES;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= gaps_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
      end
    end
  end

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus.
  initial begin
    logic [CFG_DATA_BITS-1:0] rise_v;
    logic [CFG_DATA_BITS-1:0] fall_v;
    logic [CFG_DATA_BITS-1:0] on_v;
    logic [FIELD_BITS-1:0]    raw;
    logic [FIELD_BITS-1:0]    glitch;
    logic [FIELD_BITS-1:0]    clr_rise;
    logic [FIELD_BITS-1:0]    clr_fall;

    sb                        = new();
    rst                       = 1'b1;
    gaps_on                   = 1'b1;
    stall_req                 = 1'b0;
    settings                  = 0;
    target_level              = '0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.index              = REG_RISE_HOLD;
    cfg_ch.data               = '0;
    sample_ch.valid           = 1'b0;
    sample_ch.sample_bits     = '0;
    sample_ch.clear_rise_mask = '0;
    sample_ch.clear_fall_mask = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, both holds zero: every mismatch commits at once.
    send_tick(8'h00, 8'h00, 8'h00);
    send_tick(8'hFF, 8'h00, 8'h00);
    send_tick(8'h00, 8'hFF, 8'h00);
    // Clear and commit in the same tick leave the flag set.
    send_tick(8'hFF, 8'h00, 8'hFF);
    send_tick(8'hFF, 8'hFF, 8'hFF);
    send_tick(8'hAA, 8'h55, 8'hAA);
    send_tick(8'h55, 8'hAA, 8'h55);
    send_tick(8'h55, 8'hFF, 8'hFF);

    // Inverted ON level with short holds: glitches, then holds that outlast them.
    // A channel that commits and flips straight back resumes from the kept count.
    apply_setting(16'd3, 16'd2, 16'hFFFE, 1'b1);
    send_tick(8'hFF, 8'h00, 8'h00);
    send_tick(8'hFF, 8'h00, 8'h00);
    send_tick(8'h55, 8'h00, 8'h00);
    send_tick(8'hFF, 8'h00, 8'h00);
    send_tick(8'hFF, 8'h00, 8'h00);
    send_tick(8'hFF, 8'h00, 8'h00);
    send_tick(8'hFF, 8'h00, 8'h00);
    send_tick(8'h00, 8'h0F, 8'hF0);
    send_tick(8'hFF, 8'h00, 8'h00);
    send_tick(8'hFF, 8'h00, 8'h00);
    send_tick(8'hFF, 8'h00, 8'h00);
    send_tick(8'h00, 8'h00, 8'h00);
    send_tick(8'h00, 8'h00, 8'h00);

    // High holds with no idling: a long steady mismatch builds up the counters,
    // but neither hold is exceeded, so no channel commits.
    apply_setting(16'hFFFF, 16'hFFFE, 16'h0001, 1'b0);
    gaps_on = 1'b0;
    for (int k = 0; k < LONG_TICKS; k++)
      send_tick(8'hFF, 8'($urandom) & 8'($urandom), 8'($urandom) & 8'($urandom));
    for (int k = 0; k < LONG_TICKS; k++)
      send_tick(8'h00, 8'($urandom) & 8'($urandom), 8'($urandom) & 8'($urandom));
    send_tick(8'hFF, 8'hFF, 8'hFF);
    gaps_on = 1'b1;

    // Random phases: mostly bouncing inputs around slowly moving levels, some noise.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin rise_v = 16'd0;    fall_v = 16'd0;    on_v = 16'hFFFF; end
        1: begin rise_v = 16'hFFFF; fall_v = 16'd1;    on_v = 16'h0000; end
        2: begin rise_v = 16'd2;    fall_v = 16'hFFFF; on_v = 16'h0001; end
        default: begin
          rise_v = CFG_DATA_BITS'($urandom_range(0, 6));
          fall_v = CFG_DATA_BITS'($urandom_range(0, 6));
          on_v   = CFG_DATA_BITS'($urandom_range(0, 16'hFFFF));
        end
      endcase
      apply_setting(rise_v, fall_v, on_v, p == RANDOM_PHASES - 1);
      // The output side holds off for a while so the block backs up.
      if (p == 3) stall_req = 1'b1;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == 5 && k == PHASE_WORDS / 2) pause_until_drained();
        if ($urandom_range(0, 4) == 0) begin
          raw = 8'($urandom);
        end else begin
          glitch = '0;
          for (int b = 0; b < FIELD_BITS; b++) begin
            if ($urandom_range(0, 15) == 0) target_level[b] = ~target_level[b];
            if ($urandom_range(0, 9) == 0) glitch[b] = 1'b1;
          end
          raw = target_level ^ glitch;
        end
        case ($urandom_range(0, 9))
          0:       begin clr_rise = 8'hFF; clr_fall = 8'hFF; end
          1:       begin clr_rise = 8'h00; clr_fall = 8'h00; end
          default: begin
            clr_rise = 8'($urandom) & 8'($urandom) & 8'($urandom);
            clr_fall = 8'($urandom) & 8'($urandom) & 8'($urandom);
          end
        endcase
        send_tick(raw, clr_rise, clr_fall);
      end
    end

    pause_until_drained();
    repeat (DRAIN_PAD) @(posedge clk);
    $display("Covered %0d sampling words under %0d register settings, with a %0d-tick run.",
             sb.noted, settings, LONG_TICKS);
    $display("Predicted %0d rise and %0d fall commits; %0d result words checked.",
             sb.rise_commits, sb.fall_commits, sb.checked);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
